[sv/tcc_pkg.sv]
// Shared constants and types for the triangle circumcenter core.
package tcc_pkg;

	// Field widths.
	localparam int CoordW = 16;
	localparam int NumW = 50;
	localparam int AreaW = 34;
	localparam int OutW = 48;

	// Divider sizing: one quotient bit per stage, 48 magnitude bits.
	localparam int DenW = AreaW + 1;
	localparam int DivStages = OutW;
	localparam int RemW = 84;
	localparam int FracBits = 16;
	localparam int DivLat = DivStages + 2;

	// Queue between front and back.
	localparam int FifoDepth = 4;
	localparam int FifoAw = 2;

	// Saturation limits.
	localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
	localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

	// Numerators and doubled area of one triangle.
	typedef struct packed {
		logic signed [NumW-1:0] nx;
		logic signed [NumW-1:0] ny;
		logic signed [AreaW-1:0] area;
	} tcc_frac_t;

endpackage

[sv/tcc_front.sv]
// Front part: squared norms, products and sums giving numerators and doubled area.
module tcc_front import tcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [CoordW-1:0] top_x,
	input  logic signed [CoordW-1:0] top_y,
	input  logic signed [CoordW-1:0] right_x,
	input  logic signed [CoordW-1:0] right_y,
	input  logic signed [CoordW-1:0] left_x,
	input  logic signed [CoordW-1:0] left_y,
	output logic push_valid,
	input  logic push_ready,
	output tcc_frac_t push_data
);

	logic front_en;
	logic v_s1, v_s2, v_s3;

	logic signed [32:0] tx_w, ty_w, rx_w, ry_w, lx_w, ly_w;
	logic signed [32:0] st_s1, sr_s1, sl_s1;
	logic signed [CoordW-1:0] tx_s1, ty_s1, rx_s1, ry_s1, lx_s1, ly_s1;
	logic signed [CoordW:0] dy_s1, dx_s1;

	logic signed [NumW-1:0] e_st, e_sr, e_sl, e_dy, e_dx, e_tx, e_ty, e_rx, e_ry, e_lx, e_ly;
	logic signed [NumW-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [NumW-1:0] q1_s2, q2_s2, q3_s2, q4_s2;
	logic signed [NumW-1:0] a1_s2, a2_s2, a3_s2, a4_s2;
	logic signed [NumW-1:0] area_sum;
	tcc_frac_t frac_s3;

	// The pipeline moves whenever the last stage can leave or is empty.
	assign front_en = push_ready || !v_s3;
	assign in_ready = front_en;
	assign push_valid = v_s3;
	assign push_data = frac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: squared norms and coordinate differences.
	assign tx_w = 33'(top_x);
	assign ty_w = 33'(top_y);
	assign rx_w = 33'(right_x);
	assign ry_w = 33'(right_y);
	assign lx_w = 33'(left_x);
	assign ly_w = 33'(left_y);

	always_ff @(posedge clk) begin
		if (front_en) begin
			st_s1 <= tx_w * tx_w + ty_w * ty_w;
			sr_s1 <= rx_w * rx_w + ry_w * ry_w;
			sl_s1 <= lx_w * lx_w + ly_w * ly_w;
			dy_s1 <= 17'(right_y) - 17'(left_y);
			dx_s1 <= 17'(left_x) - 17'(right_x);
			tx_s1 <= top_x;
			ty_s1 <= top_y;
			rx_s1 <= right_x;
			ry_s1 <= right_y;
			lx_s1 <= left_x;
			ly_s1 <= left_y;
		end
	end

	// Stage 2: the twelve products, each at full numerator width.
	assign e_st = NumW'(st_s1);
	assign e_sr = NumW'(sr_s1);
	assign e_sl = NumW'(sl_s1);
	assign e_dy = NumW'(dy_s1);
	assign e_dx = NumW'(dx_s1);
	assign e_tx = NumW'(tx_s1);
	assign e_ty = NumW'(ty_s1);
	assign e_rx = NumW'(rx_s1);
	assign e_ry = NumW'(ry_s1);
	assign e_lx = NumW'(lx_s1);
	assign e_ly = NumW'(ly_s1);

	always_ff @(posedge clk) begin
		if (front_en) begin
			p1_s2 <= e_st * e_dy;
			p2_s2 <= e_ty * (e_sl - e_sr);
			p3_s2 <= e_sr * e_ly;
			p4_s2 <= e_sl * e_ry;
			q1_s2 <= e_tx * (e_sr - e_sl);
			q2_s2 <= e_st * e_dx;
			q3_s2 <= e_rx * e_sl;
			q4_s2 <= e_sr * e_lx;
			a1_s2 <= e_tx * e_dy;
			a2_s2 <= e_ty * e_dx;
			a3_s2 <= e_rx * e_ly;
			a4_s2 <= e_ry * e_lx;
		end
	end

	// Stage 3: sums; the exact values fit their widths.
	assign area_sum = a1_s2 + a2_s2 + a3_s2 - a4_s2;

	always_ff @(posedge clk) begin
		if (front_en) begin
			frac_s3.nx <= p1_s2 + p2_s2 + p3_s2 - p4_s2;
			frac_s3.ny <= q1_s2 + q2_s2 + q3_s2 - q4_s2;
			frac_s3.area <= area_sum[AreaW-1:0];
		end
	end

endmodule

[sv/tcc_fifo.sv]
// Short queue that decouples the front part from the divider back part.
module tcc_fifo import tcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  tcc_frac_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output tcc_frac_t pop_data
);

	tcc_frac_t mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [FifoAw:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != (FifoAw+1)'(FifoDepth));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[sv/tcc_div.sv]
// Pipelined restoring divider giving the magnitude of num * 2^16 / (2 * area).
module tcc_div import tcc_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic signed [NumW-1:0] num,
	input  logic signed [AreaW-1:0] area,
	output logic [OutW-1:0] mag,
	output logic ovf,
	output logic neg
);

	logic [NumW-1:0] an_s1;
	logic [DenW-1:0] ad_s1;
	logic neg_s1;
	logic [AreaW-1:0] area_abs;

	logic [RemW-1:0] rem_s [DivStages+1];
	logic [DenW-1:0] den_s [DivStages+1];
	logic [OutW-1:0] quo_s [DivStages+1];
	logic neg_s [DivStages+1];
	logic ovf_s [DivStages+1];

	assign area_abs = area[AreaW-1] ? AreaW'(-area) : AreaW'(area);

	// Stage 1: magnitudes and result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= num[NumW-1] ? NumW'(-num) : NumW'(num);
			ad_s1 <= {area_abs, 1'b0};
			neg_s1 <= num[NumW-1] ^ area[AreaW-1];
		end
	end

	// Stage 2: quotient of 2^48 or more is flagged; scale the dividend.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (RemW'(an_s1) >= RemW'({ad_s1, 32'b0}));
			rem_s[0] <= RemW'({an_s1, {FracBits{1'b0}}});
			den_s[0] <= ad_s1;
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < DivStages; k++) begin : g_bit
		localparam int Sh = DivStages - 1 - k;
		logic [RemW-1:0] trial;

		assign trial = rem_s[k] - (RemW'(den_s[k]) << Sh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= trial[RemW-1] ? rem_s[k] : trial;
				quo_s[k+1] <= {quo_s[k][OutW-2:0], !trial[RemW-1]};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign mag = quo_s[DivStages];
	assign ovf = ovf_s[DivStages];
	assign neg = neg_s[DivStages];

endmodule

[sv/tcc_back.sv]
// Back part: two divider lanes, collinear tracking, sign, clamp and output register.
module tcc_back import tcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  tcc_frac_t pop_data,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OutW-1:0] center_x,
	output logic signed [OutW-1:0] center_y,
	output logic collinear,
	output logic saturated
);

	logic back_en;
	logic vld_s [DivLat];
	logic zero_s [DivLat];
	logic out_valid_q;
	logic [OutW-1:0] mag_x, mag_y;
	logic ovf_x, ovf_y, neg_x, neg_y;
	logic signed [OutW-1:0] val_x, val_y;
	logic sat_x, sat_y;

	// The whole back pipeline holds while a result waits at the output.
	assign back_en = !out_valid_q || out_ready;
	assign pop_ready = back_en;
	assign out_valid = out_valid_q;

	tcc_div u_div_x (
		.clk  (clk),
		.en   (back_en),
		.num  (pop_data.nx),
		.area (pop_data.area),
		.mag  (mag_x),
		.ovf  (ovf_x),
		.neg  (neg_x)
	);

	tcc_div u_div_y (
		.clk  (clk),
		.en   (back_en),
		.num  (pop_data.ny),
		.area (pop_data.area),
		.mag  (mag_y),
		.ovf  (ovf_y),
		.neg  (neg_y)
	);

	// Valid bits alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DivLat; i++) vld_s[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			vld_s[0] <= pop_valid;
			for (int i = 1; i < DivLat; i++) vld_s[i] <= vld_s[i-1];
			out_valid_q <= vld_s[DivLat-1];
		end
	end

	// Collinear flag travels with the request.
	always_ff @(posedge clk) begin
		if (back_en) begin
			zero_s[0] <= (pop_data.area == '0);
			for (int i = 1; i < DivLat; i++) zero_s[i] <= zero_s[i-1];
		end
	end

	// Apply sign and clamp to the 48-bit range.
	always_comb begin
		if (neg_x) begin
			sat_x = ovf_x || (mag_x > {1'b1, {(OutW-1){1'b0}}});
			val_x = sat_x ? OutMin : OutW'(-mag_x);
		end else begin
			sat_x = ovf_x || mag_x[OutW-1];
			val_x = sat_x ? OutMax : OutW'(mag_x);
		end
		if (neg_y) begin
			sat_y = ovf_y || (mag_y > {1'b1, {(OutW-1){1'b0}}});
			val_y = sat_y ? OutMin : OutW'(-mag_y);
		end else begin
			sat_y = ovf_y || mag_y[OutW-1];
			val_y = sat_y ? OutMax : OutW'(mag_y);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (back_en) begin
			if (zero_s[DivLat-1]) begin
				center_x <= '0;
				center_y <= '0;
				collinear <= 1'b1;
				saturated <= 1'b0;
			end else begin
				center_x <= val_x;
				center_y <= val_y;
				collinear <= 1'b0;
				saturated <= sat_x || sat_y;
			end
		end
	end

endmodule

[sv/triangle_circumcenter_core.sv]
// Top level of the triangle circumcenter core.
// Takes one triangle per clock cycle while in_ready is high and returns its
// circumcenter as signed Q31.16, truncated toward zero and clamped to 48 bits,
// with collinear and saturated flags. A request passes through the product front
// end, the four-entry request queue and the back end, whose depth is set by the
// divider pipeline that resolves one quotient bit per stage for each coordinate.
// A stall at the output holds the back end; the queue lets the front end keep
// taking requests until it fills.
module triangle_circumcenter_core import tcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [CoordW-1:0] top_x,
	input  logic signed [CoordW-1:0] top_y,
	input  logic signed [CoordW-1:0] right_x,
	input  logic signed [CoordW-1:0] right_y,
	input  logic signed [CoordW-1:0] left_x,
	input  logic signed [CoordW-1:0] left_y,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OutW-1:0] center_x,
	output logic signed [OutW-1:0] center_y,
	output logic collinear,
	output logic saturated
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	tcc_frac_t push_data, pop_data;

	tcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.top_x      (top_x),
		.top_y      (top_y),
		.right_x    (right_x),
		.right_y    (right_y),
		.left_x     (left_x),
		.left_y     (left_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tcc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.center_x  (center_x),
		.center_y  (center_y),
		.collinear (collinear),
		.saturated (saturated)
	);

	// A collinear result is a zero center that is never clamped.
	a_collinear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collinear |-> center_x == '0 && center_y == '0 && !saturated)
		else $error("collinear result with nonzero center");

	// A clamped result carries a limit value in at least one coordinate.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> !collinear && (center_x == OutMax || center_x == OutMin
			|| center_y == OutMax || center_y == OutMin))
		else $error("saturated flag without a limit value");

	// The front end must stall while the queue refuses its last stage.
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |-> !in_ready)
		else $error("front end accepted while blocked by a full queue");

endmodule
